// ===== src/tt2l_pkg.sv =====
package tt2l_pkg;

    // LCD instruction codes.
    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_UPPER = 8'h80;
    localparam logic [7:0] INSTR_LOWER = 8'hc0;

    // Control characters and the pad character.
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Source of the byte loaded into the output register.
    typedef enum logic [2:0] {
        SRC_DATA   = 3'd0,
        SRC_CR     = 3'd1,
        SRC_CLEAR  = 3'd2,
        SRC_HOME   = 3'd3,
        SRC_REPLAY = 3'd4,
        SRC_LOWER  = 3'd5
    } t_src;

    typedef struct packed {
        logic accept;
        logic emit;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic is_cr;
        logic is_ff;
        logic is_nl;
        logic lower;
        logic wrap;
        logic slot_free;
        logic replay_end;
    } t_sts;

endpackage

// ===== src/tt2l_char_if.sv =====
interface tt2l_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

// ===== src/tt2l_lcd_if.sv =====
interface tt2l_lcd_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;

    modport source (output valid, output is_data, output lcd_byte, output last, input ready);
    modport sink (input valid, input is_data, input lcd_byte, input last, output ready);
endinterface

// ===== src/text_terminal_to_lcd_commands_core.sv =====
// After a character's transfer the controller leaves idle, and the first LCD write of the
// character is loaded into the output register once that register is free. Throughput:
// one LCD write per cycle while the sink is ready. The sequencer emits the writes through
// one register, and the input stays not ready until the last write is loaded.
// Reset (synchronous, active low) puts the cursor on the upper row at the left edge and
// empties the output register; the stored lower row is not cleared.
module text_terminal_to_lcd_commands_core #(
    parameter int ROW_LENGTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tt2l_char_if.sink   i_char,
    tt2l_lcd_if.source  o_lcd
);

    // The controller only steps through the write sequence of one character; the
    // datapath owns the cursor state, the stored lower row and the output register.
    tt2l_pkg::t_cmd w_cmd;
    tt2l_pkg::t_sts w_sts;

    // A character transfer happens only while the controller is idle. From then on
    // each write is loaded into the output register as soon as that register is free
    // or is being emptied by a transfer on the LCD side in the same cycle.
    tt2l_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (i_char.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // During a scroll the stored row is read one entry ahead, so the replayed
    // characters leave at one per cycle while the LCD side is ready; columns
    // at or past the count are padded with spaces.
    tt2l_datapath #(
        .ROW_LENGTH (ROW_LENGTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_char_code (i_char.char_code),
        .o_valid     (o_lcd.valid),
        .i_ready     (o_lcd.ready),
        .o_is_data   (o_lcd.is_data),
        .o_lcd_byte  (o_lcd.lcd_byte),
        .o_last      (o_lcd.last)
    );

endmodule

// ===== src/tt2l_ctrl.sv =====
module tt2l_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tt2l_pkg::t_sts  i_sts,
    output tt2l_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DATA   = 7'b0000010,
        ST_CR     = 7'b0000100,
        ST_CLEAR  = 7'b0001000,
        ST_HOME   = 7'b0010000,
        ST_REPLAY = 7'b0100000,
        ST_LOWER  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_scroll, n_scroll;
    logic   r_tail_lower, n_tail_lower;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_scroll     = r_scroll;
        n_tail_lower = r_tail_lower;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.src    = tt2l_pkg::SRC_DATA;
        o_cmd.last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_scroll     = 1'b0;
                    n_tail_lower = 1'b0;
                    if (i_sts.is_cr) begin
                        n_state = ST_CR;
                    end else if (i_sts.is_ff) begin
                        n_state = ST_CLEAR;
                    end else if (i_sts.is_nl) begin
                        if (i_sts.lower) begin
                            n_state  = ST_CLEAR;
                            n_scroll = 1'b1;
                        end else begin
                            n_state = ST_LOWER;
                        end
                    end else begin
                        n_state      = ST_DATA;
                        n_scroll     = i_sts.lower & i_sts.wrap;
                        n_tail_lower = ~i_sts.lower & i_sts.wrap;
                    end
                end
            end
            ST_DATA: begin
                o_cmd.src  = tt2l_pkg::SRC_DATA;
                o_cmd.last = ~r_scroll & ~r_tail_lower;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_scroll) begin
                        n_state = ST_CLEAR;
                    end else if (r_tail_lower) begin
                        n_state = ST_LOWER;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CR: begin
                o_cmd.src  = tt2l_pkg::SRC_CR;
                o_cmd.last = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.src = tt2l_pkg::SRC_CLEAR;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_HOME;
                end
            end
            ST_HOME: begin
                o_cmd.src  = tt2l_pkg::SRC_HOME;
                o_cmd.last = ~r_scroll;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = r_scroll ? ST_REPLAY : ST_IDLE;
                end
            end
            ST_REPLAY: begin
                o_cmd.src = tt2l_pkg::SRC_REPLAY;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.replay_end) begin
                        n_state = ST_LOWER;
                    end
                end
            end
            ST_LOWER: begin
                o_cmd.src  = tt2l_pkg::SRC_LOWER;
                o_cmd.last = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scroll     <= 1'b0;
            r_tail_lower <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scroll     <= n_scroll;
            r_tail_lower <= n_tail_lower;
        end
    end

endmodule

// ===== src/tt2l_datapath.sv =====
module tt2l_datapath #(
    parameter int ROW_LENGTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tt2l_pkg::t_cmd  i_cmd,
    output tt2l_pkg::t_sts  o_sts,
    input  logic [7:0]      i_char_code,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_is_data,
    output logic [7:0]      o_lcd_byte,
    output logic            o_last
);

    localparam int CW = $clog2(ROW_LENGTH + 2);
    localparam int AW = $clog2(ROW_LENGTH);
    localparam logic [CW-1:0] COL_ONE  = CW'(1);
    localparam logic [CW-1:0] COL_LAST = CW'(ROW_LENGTH);
    localparam logic [CW-1:0] COL_ALL  = CW'(ROW_LENGTH + 1);
    localparam logic [AW-1:0] IDX_END  = AW'(ROW_LENGTH - 1);

    logic [7:0]    r_row_mem [ROW_LENGTH];
    logic [7:0]    r_rd_data;
    logic [7:0]    r_char;
    logic          r_lower, n_lower;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_limit;
    logic [AW-1:0] r_idx;
    logic          r_out_valid;
    logic          r_out_is_data;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          w_printable;
    logic          w_wrap;
    logic [CW-1:0] w_wr_col;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_byte;
    logic          w_is_data;

    assign w_printable = (i_char_code != tt2l_pkg::CH_CR) && (i_char_code != tt2l_pkg::CH_FF)
                         && (i_char_code != tt2l_pkg::CH_NL);
    assign w_wrap   = (r_count == COL_LAST);
    assign w_wr_col = r_count - COL_ONE;
    assign w_wr_en  = i_cmd.accept && w_printable && r_lower;

    assign o_sts.is_cr      = (i_char_code == tt2l_pkg::CH_CR);
    assign o_sts.is_ff      = (i_char_code == tt2l_pkg::CH_FF);
    assign o_sts.is_nl      = (i_char_code == tt2l_pkg::CH_NL);
    assign o_sts.lower      = r_lower;
    assign o_sts.wrap       = w_wrap;
    assign o_sts.slot_free  = ~r_out_valid | i_ready;
    assign o_sts.replay_end = (r_idx == IDX_END);

    // Row and column update at the moment the character is taken.
    always_comb begin
        n_lower = r_lower;
        n_count = r_count;
        if (i_cmd.accept) begin
            if (i_char_code == tt2l_pkg::CH_FF) begin
                n_lower = 1'b0;
                n_count = COL_ONE;
            end else if (i_char_code == tt2l_pkg::CH_NL) begin
                n_lower = 1'b1;
                n_count = COL_ONE;
            end else if (w_printable) begin
                if (w_wrap) begin
                    n_lower = 1'b1;
                    n_count = COL_ONE;
                end else begin
                    n_count = r_count + COL_ONE;
                end
            end
        end
    end

    // The stored row is read one entry ahead of the replay pointer.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (i_cmd.emit && (i_cmd.src == tt2l_pkg::SRC_HOME)) begin
            w_rd_en = 1'b1;
        end else if (i_cmd.emit && (i_cmd.src == tt2l_pkg::SRC_REPLAY)
                     && (r_idx != IDX_END)) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_idx + AW'(1);
        end
    end

    always_comb begin
        w_is_data = 1'b0;
        w_byte    = r_char;
        case (i_cmd.src)
            tt2l_pkg::SRC_DATA: begin
                w_is_data = 1'b1;
                w_byte    = r_char;
            end
            tt2l_pkg::SRC_CR: begin
                w_byte = r_lower ? tt2l_pkg::INSTR_LOWER : tt2l_pkg::INSTR_UPPER;
            end
            tt2l_pkg::SRC_CLEAR: begin
                w_byte = tt2l_pkg::INSTR_CLEAR;
            end
            tt2l_pkg::SRC_HOME: begin
                w_byte = tt2l_pkg::INSTR_UPPER;
            end
            tt2l_pkg::SRC_REPLAY: begin
                w_is_data = 1'b1;
                w_byte    = ((CW'(r_idx) + COL_ONE) < r_limit) ? r_rd_data
                                                                : tt2l_pkg::CH_SPACE;
            end
            tt2l_pkg::SRC_LOWER: begin
                w_byte = tt2l_pkg::INSTR_LOWER;
            end
            default: begin
                w_byte = r_char;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_row_mem[w_wr_col[AW-1:0]] <= i_char_code;
        end
        if (w_rd_en) begin
            r_rd_data <= r_row_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char  <= i_char_code;
            r_limit <= (i_char_code == tt2l_pkg::CH_NL) ? r_count : COL_ALL;
        end
        if (i_cmd.emit && (i_cmd.src == tt2l_pkg::SRC_HOME)) begin
            r_idx <= '0;
        end else if (i_cmd.emit && (i_cmd.src == tt2l_pkg::SRC_REPLAY)) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.emit) begin
            r_out_is_data <= w_is_data;
            r_out_byte    <= w_byte;
            r_out_last    <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= 1'b0;
            r_count     <= COL_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_lower <= n_lower;
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_is_data  = r_out_is_data;
    assign o_lcd_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ===== tb/sv/text_terminal_to_lcd_commands_core_test.sv =====
`timescale 1ns / 1ps

// This bench checks the terminal-to-LCD sequencer against a predictor of the display state.
// The predictor tracks the cursor row, the column count and the lower-row copy.
// The character stream starts with a directed table and then moves to random bursts.
// The amount of control codes differs from burst to burst, so the bench reaches both
// the right-edge wrap and the lower-row scroll.
// Both handshakes idle at random. One long stall on the LCD side fills the block
// and pushes back on the character input.
module text_terminal_to_lcd_commands_core_test;

    localparam int ROW_LEN           = 16;
    localparam int CLK_PERIOD        = 20;
    localparam int RANDOM_CHARS      = 385;
    localparam int BURST_CHARS       = 24;
    localparam int HOLD_AFTER_WRITES = 300;
    localparam int HOLD_CYCLES       = 400;
    localparam int DRAIN_CYCLES      = 60;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int MAX_REPORTS       = 40;
    localparam int MAX_IDLE          = 17;

    // One LCD write, in the same field order as the result channel.
    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } t_lcd_write;

    // One row of the directed table. A row with n_typed set to zero is checked
    // against the predictor. Other rows carry their writes typed in.
    typedef struct packed {
        logic [7:0] code;
        logic [4:0] reps;
        logic [1:0] n_typed;
        t_lcd_write first;
        t_lcd_write second;
    } t_char_row;

    localparam t_lcd_write NO_WRITE = '0;
    localparam int N_ROWS = 11;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tt2l_char_if char_bus ();
    tt2l_lcd_if  lcd_bus ();

    text_terminal_to_lcd_commands_core #(
        .ROW_LENGTH(ROW_LEN)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (char_bus),
        .o_lcd  (lcd_bus)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // The table opens with the cases that are plain to see after reset. Carriage return
    // and form feed come first on the upper row. Newline then moves the cursor down, and
    // the byte extremes are printed on the lower row. The newline after them scrolls with
    // a partly stored row. Sixteen characters then fill the lower row, so the last of
    // them forces a scroll that replays the whole row. A byte that lies between two
    // control codes must print as is.
    t_char_row directed_rows [N_ROWS] = '{
        '{tt2l_pkg::CH_CR, 5'd1, 2'd1,
          '{1'b0, tt2l_pkg::INSTR_UPPER, 1'b1}, NO_WRITE},
        '{tt2l_pkg::CH_FF, 5'd1, 2'd2,
          '{1'b0, tt2l_pkg::INSTR_CLEAR, 1'b0}, '{1'b0, tt2l_pkg::INSTR_UPPER, 1'b1}},
        '{tt2l_pkg::CH_NL, 5'd1, 2'd1,
          '{1'b0, tt2l_pkg::INSTR_LOWER, 1'b1}, NO_WRITE},
        '{tt2l_pkg::CH_CR, 5'd1, 2'd1,
          '{1'b0, tt2l_pkg::INSTR_LOWER, 1'b1}, NO_WRITE},
        '{8'h00, 5'd1, 2'd1, '{1'b1, 8'h00, 1'b1}, NO_WRITE},
        '{8'hff, 5'd1, 2'd1, '{1'b1, 8'hff, 1'b1}, NO_WRITE},
        '{tt2l_pkg::CH_NL, 5'd1, 2'd0, NO_WRITE, NO_WRITE},
        '{8'hf0, 5'd16, 2'd0, NO_WRITE, NO_WRITE},
        '{tt2l_pkg::CH_FF, 5'd1, 2'd2,
          '{1'b0, tt2l_pkg::INSTR_CLEAR, 1'b0}, '{1'b0, tt2l_pkg::INSTR_UPPER, 1'b1}},
        '{8'h0b, 5'd1, 2'd0, NO_WRITE, NO_WRITE},
        '{tt2l_pkg::CH_NL, 5'd1, 2'd1,
          '{1'b0, tt2l_pkg::INSTR_LOWER, 1'b1}, NO_WRITE}
    };

    // The predictor's copy of the display state.
    logic       term_on_lower;
    int         term_column;
    logic [7:0] term_lower_row [ROW_LEN];

    // These are the writes of the current character, and then all writes still to come.
    t_lcd_write char_writes [ROW_LEN + 4];
    int         n_char_writes;
    t_lcd_write lcd_writes_due [$];

    int  mismatches     = 0;
    int  chars_sent     = 0;
    int  writes_checked = 0;
    int  scroll_count   = 0;
    int  wrap_count     = 0;
    // When this flag is set, both sides run without gaps for the current burst.
    bit  calm           = 1'b0;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic void add_write(input logic is_data, input logic [7:0] value);
        char_writes[n_char_writes] = '{is_data, value, 1'b0};
        n_char_writes++;
    endfunction

    // A scroll clears the display and homes the cursor. It then rewrites the upper row
    // from the stored lower row. Columns below the count are replayed from the copy, and
    // the remaining columns are padded with spaces. Last, the cursor moves to the lower row.
    function automatic void add_scroll();
        int col;
        add_write(1'b0, tt2l_pkg::INSTR_CLEAR);
        add_write(1'b0, tt2l_pkg::INSTR_UPPER);
        for (col = 1; col <= ROW_LEN; col++) begin
            if (col < term_column) begin
                add_write(1'b1, term_lower_row[col - 1]);
            end else begin
                add_write(1'b1, tt2l_pkg::CH_SPACE);
            end
        end
        add_write(1'b0, tt2l_pkg::INSTR_LOWER);
        scroll_count++;
    endfunction

    // This function works out the LCD writes for one accepted character and updates
    // the predicted state.
    function automatic void predict_lcd_writes(input logic [7:0] code);
        n_char_writes = 0;
        if (code == tt2l_pkg::CH_CR) begin
            // The cursor returns to the left edge. The row and the count stay as they are.
            add_write(1'b0, term_on_lower ? tt2l_pkg::INSTR_LOWER : tt2l_pkg::INSTR_UPPER);
        end else if (code == tt2l_pkg::CH_FF) begin
            term_on_lower = 1'b0;
            term_column   = 1;
            add_write(1'b0, tt2l_pkg::INSTR_CLEAR);
            add_write(1'b0, tt2l_pkg::INSTR_UPPER);
        end else if (code == tt2l_pkg::CH_NL) begin
            if (term_on_lower) begin
                add_scroll();
            end else begin
                add_write(1'b0, tt2l_pkg::INSTR_LOWER);
            end
            term_on_lower = 1'b1;
            term_column   = 1;
        end else if (term_on_lower) begin
            // A character on the lower row is stored first, so that a later scroll
            // can replay it.
            term_lower_row[term_column - 1] = code;
            add_write(1'b1, code);
            term_column++;
            if (term_column > ROW_LEN) begin
                add_scroll();
                term_column = 1;
            end
        end else begin
            add_write(1'b1, code);
            term_column++;
            if (term_column > ROW_LEN) begin
                add_write(1'b0, tt2l_pkg::INSTR_LOWER);
                term_on_lower = 1'b1;
                term_column   = 1;
                wrap_count++;
            end
        end
        char_writes[n_char_writes - 1].last = 1'b1;
    endfunction

    // This task offers one character and returns at the clock edge of its transfer.
    // The task always starts and ends on a rising edge, so valid stays high from one
    // character to the next when there is no gap.
    task automatic send_char(input logic [7:0] code, input logic [1:0] n_typed,
                             input t_lcd_write first, input t_lcd_write second);
        int gap;
        int k;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        // Handshake values are read just after the edge, before any register update
        // of that edge. The loop therefore sees what the block saw.
        do @(posedge i_clk); while (!char_bus.ready);
        chars_sent++;
        predict_lcd_writes(code);
        if (n_typed == 2'd0) begin
            for (k = 0; k < n_char_writes; k++) begin
                lcd_writes_due.push_back(char_writes[k]);
            end
        end else begin
            lcd_writes_due.push_back(first);
            if (n_typed == 2'd2) begin
                lcd_writes_due.push_back(second);
            end
        end
    endtask

    task automatic check_lcd_write(input t_lcd_write seen);
        t_lcd_write due;
        writes_checked++;
        if (lcd_writes_due.size() == 0) begin
            flag_mismatch($sformatf("LCD write is_data=%0b byte=%02h last=%0b with none pending",
                                    seen.is_data, seen.lcd_byte, seen.last));
        end else begin
            due = lcd_writes_due.pop_front();
            if (seen.is_data !== due.is_data) begin
                flag_mismatch($sformatf("write %0d: is_data %0b, wanted %0b",
                                        writes_checked, seen.is_data, due.is_data));
            end
            if (seen.lcd_byte !== due.lcd_byte) begin
                flag_mismatch($sformatf("write %0d: byte %02h, wanted %02h",
                                        writes_checked, seen.lcd_byte, due.lcd_byte));
            end
            if (seen.last !== due.last) begin
                flag_mismatch($sformatf("write %0d: last %0b, wanted %0b",
                                        writes_checked, seen.last, due.last));
            end
        end
    endtask

    // This process models the display side. For each write it draws how long it keeps
    // ready low. Once, after a fixed number of writes, it holds ready low for a long
    // stretch, and the sequencer then backs up into the character input.
    initial begin : lcd_sink
        int         stall;
        bit         hold_done;
        t_lcd_write seen;
        hold_done = 1'b0;
        lcd_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && writes_checked >= HOLD_AFTER_WRITES) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                lcd_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            lcd_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!lcd_bus.valid);
            seen = '{lcd_bus.is_data, lcd_bus.lcd_byte, lcd_bus.last};
            check_lcd_write(seen);
        end
    end

    // This process drives reset and the character stream. It then waits for the last
    // expected write and gives the verdict.
    initial begin : char_source
        int         ctrl_pct;
        int         i;
        int         k;
        logic [7:0] code;
        ctrl_pct = 0;
        i_rst_n            <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= 8'h00;
        // Reset puts the cursor at the upper left. The row copy is unknown until it is written.
        term_on_lower = 1'b0;
        term_column   = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++) begin
            for (k = 0; k < directed_rows[i].reps; k++) begin
                send_char(directed_rows[i].code + 8'(k), directed_rows[i].n_typed,
                          directed_rows[i].first, directed_rows[i].second);
            end
        end

        // Random bursts. Bursts without control codes run on past the right edge, so
        // the upper row wraps and the lower row scrolls. Bursts rich in control codes
        // mix newline, form feed and carriage return in every state.
        for (i = 0; i < RANDOM_CHARS; i++) begin
            if (i % BURST_CHARS == 0) begin
                case ($urandom_range(0, 3))
                    0:       ctrl_pct = 0;
                    1:       ctrl_pct = 4;
                    2:       ctrl_pct = 15;
                    default: ctrl_pct = 40;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < ctrl_pct) begin
                case ($urandom_range(0, 3))
                    0, 1:    code = tt2l_pkg::CH_NL;
                    2:       code = tt2l_pkg::CH_CR;
                    default: code = tt2l_pkg::CH_FF;
                endcase
            end else begin
                do begin
                    code = 8'($urandom_range(0, 255));
                end while (code == tt2l_pkg::CH_NL || code == tt2l_pkg::CH_FF
                           || code == tt2l_pkg::CH_CR);
            end
            send_char(code, 2'd0, NO_WRITE, NO_WRITE);
        end
        char_bus.valid <= 1'b0;
        calm = 1'b0;

        // Every write still pending must arrive. A few more cycles then catch any
        // write that should not be there.
        while (lcd_writes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters, including %0d upper-row wraps and %0d scrolls.",
                 chars_sent, wrap_count, scroll_count);
        $display("Checked %0d LCD writes with random idling and one %0d-cycle sink stall.",
                 writes_checked, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("Timed out with %0d LCD writes still pending.", lcd_writes_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/tt2l_pkg.sv
src/tt2l_char_if.sv
src/tt2l_lcd_if.sv
src/tt2l_ctrl.sv
src/tt2l_datapath.sv
src/text_terminal_to_lcd_commands_core.sv
tb/sv/text_terminal_to_lcd_commands_core_test.sv
